@@ hw/rtl/accel_tilt_deadband_corrector_assert.svh @@
// Assertion macros for the tilt corrector.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef ACCEL_TILT_DEADBAND_CORRECTOR_ASSERT_SVH
`define ACCEL_TILT_DEADBAND_CORRECTOR_ASSERT_SVH

// Antecedent in the same cycle implies the consequent.
`define ATDC_ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("atdc assertion failed");

// Antecedent implies the consequent in the next cycle.
`define ATDC_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("atdc assertion failed");

`endif

@@ hw/rtl/atdc_pkg.sv @@
// Shared types, constants and the arctangent table of the tilt corrector.
// Depends on nothing.
package atdc_pkg;

   localparam int AXIS_W          = 16;
   localparam int OUT_W           = 16;
   localparam int CFG_W           = 17;
   localparam int DB_W            = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int SQ_W            = 31;
   localparam int SUM_W           = 32;
   localparam int RAD_W           = 48;
   localparam int ROOT_W          = 24;
   localparam int REM_W           = 26;
   localparam int OPND_W          = 24;
   localparam int SQRT_STEPS      = 24;
   localparam int CW              = 28;
   localparam int ACC_FRAC        = 24;
   localparam int AW              = 34;
   localparam int TAB_LEN         = 24;
   localparam int TAB_W           = 30;
   localparam int ERR_W           = 24;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_FRAC_DEF  = 8;
   localparam logic [DB_W-1:0] DB_XY_RESET = 16'd640;
   localparam logic [DB_W-1:0] DB_Z_RESET  = 16'd256;

   typedef enum logic [1:0] {
      TURN_NONE = 2'd0,
      TURN_CW   = 2'd1,
      TURN_CCW  = 2'd2
   } turn_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_X = 3'd0,
      CSR_REF_Y = 3'd1,
      CSR_REF_Z = 3'd2,
      CSR_DB_XY = 3'd3,
      CSR_DB_Z  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [RAD_W-1:0]         rad;
      logic [REM_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
      logic signed [OPND_W-1:0] side;
   } sqrt_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] acc;
      logic                 zero;
   } cordic_type;

   function automatic logic [TAB_W-1:0] atan_entry(input int idx);
      logic [TAB_W-1:0] v;
      case (idx)
         0:  v = 30'd754974720;
         1:  v = 30'd445687602;
         2:  v = 30'd235489088;
         3:  v = 30'd119537938;
         4:  v = 30'd60000934;
         5:  v = 30'd30029717;
         6:  v = 30'd15018523;
         7:  v = 30'd7509720;
         8:  v = 30'd3754917;
         9:  v = 30'd1877466;
         10: v = 30'd938734;
         11: v = 30'd469367;
         12: v = 30'd234684;
         13: v = 30'd117342;
         14: v = 30'd58671;
         15: v = 30'd29335;
         16: v = 30'd14668;
         17: v = 30'd7334;
         18: v = 30'd3667;
         19: v = 30'd1833;
         20: v = 30'd917;
         21: v = 30'd458;
         22: v = 30'd229;
         23: v = 30'd115;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic turn_type turn_dec(input logic signed [ERR_W-1:0] err,
                                         input logic [DB_W-1:0] band);
      logic [ERR_W-1:0] mag;
      turn_type t;
      mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      if (mag <= ERR_W'(band)) begin
         t = TURN_NONE;
      end else if (err[ERR_W-1]) begin
         t = TURN_CCW;
      end else begin
         t = TURN_CW;
      end
      return t;
   endfunction

endpackage

@@ hw/rtl/accel_tilt_deadband_corrector.sv @@
// Throughput: one transaction per cycle; the whole cell chain advances together
// and halts only while a finished result is held under rsp_stall.
// Reset: synchronous, clears all valid bits and loads the register defaults.
// Depends on atdc_pkg, atdc_sqrt_cell, atdc_cordic_cell and the assertion header.
`include "accel_tilt_deadband_corrector_assert.svh"
module accel_tilt_deadband_corrector #(
   parameter int CORDIC_STEPS    = atdc_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = atdc_pkg::ANGLE_FRAC_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [atdc_pkg::AXIS_W-1:0]     req_accel_x,
   input  logic signed [atdc_pkg::AXIS_W-1:0]     req_accel_y,
   input  logic signed [atdc_pkg::AXIS_W-1:0]     req_accel_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [atdc_pkg::OUT_W-1:0]      rsp_tilt_x,
   output logic signed [atdc_pkg::OUT_W-1:0]      rsp_tilt_y,
   output logic [atdc_pkg::OUT_W-1:0]             rsp_tilt_z,
   output logic [1:0]                             rsp_turn_x,
   output logic [1:0]                             rsp_turn_y,
   output logic [1:0]                             rsp_turn_z,
   input  logic                                   csr_wr_en,
   input  logic [atdc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [atdc_pkg::CFG_W-1:0]             csr_wdata
);
   import atdc_pkg::*;

   localparam int NSTEP  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
   localparam int LAT    = NSTEP + SQRT_STEPS + 5;
   localparam int SH     = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int ANG_W  = ANGLE_FRAC_BITS + 10;
   localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (SH - 1));
   localparam logic signed [AW-1:0] LIM90  = AW'(64'sd90 <<< ANGLE_FRAC_BITS);
   localparam logic signed [AW-1:0] LIM180 = AW'(64'sd180 <<< ANGLE_FRAC_BITS);
   localparam logic signed [AW-1:0] ACC90  = AW'(64'sd90 <<< ACC_FRAC);

   logic                        en;
   logic [LAT-1:0]              vld_ff;
   logic [LAT-1:0]              vld_in;

   logic signed [CFG_W-1:0]     ref_x_ff, ref_y_ff, ref_z_ff;
   logic [DB_W-1:0]             db_xy_ff, db_z_ff;

   logic [SQ_W-1:0]             sq_ff [3];
   logic signed [AXIS_W-1:0]    ax_ff [3];
   sqrt_type                    sq_chain [3][SQRT_STEPS+1];
   cordic_type                  cd_chain [3][NSTEP+1];
   cordic_type                  prep_in [3];
   logic signed [ANG_W-1:0]     ang_ff [3];
   logic signed [ANG_W-1:0]     ang_in [3];

   logic signed [OUT_W-1:0]     tilt_x_ff, tilt_y_ff;
   logic [OUT_W-1:0]            tilt_z_ff;
   turn_type                    turn_x_ff, turn_y_ff, turn_z_ff;

   assign en        = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !en;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_z_ff <= '0;
         db_xy_ff <= DB_XY_RESET;
         db_z_ff  <= DB_Z_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_REF_X: ref_x_ff <= csr_wdata;
            CSR_REF_Y: ref_y_ff <= csr_wdata;
            CSR_REF_Z: ref_z_ff <= csr_wdata;
            CSR_DB_XY: db_xy_ff <= csr_wdata[DB_W-1:0];
            CSR_DB_Z:  db_z_ff  <= csr_wdata[DB_W-1:0];
            default: ;
         endcase
      end
   end

   // Squares of the three axes, then the radicands of the three lanes.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= SQ_W'(req_accel_x * req_accel_x);
         sq_ff[1] <= SQ_W'(req_accel_y * req_accel_y);
         sq_ff[2] <= SQ_W'(req_accel_z * req_accel_z);
         ax_ff[0] <= req_accel_x;
         ax_ff[1] <= req_accel_y;
         ax_ff[2] <= req_accel_z;
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      sqrt_type s1_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            s1_ff.rad  <= {SUM_W'(sq_ff[(l+1)%3]) + SUM_W'(sq_ff[(l+2)%3]), 16'h0000};
            s1_ff.rem  <= '0;
            s1_ff.root <= '0;
            s1_ff.side <= {ax_ff[l], 8'h00};
         end
      end
      assign sq_chain[l][0] = s1_ff;

      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
         atdc_sqrt_cell u_cell (
            .clock (clock),
            .en    (en),
            .d_in  (sq_chain[l][k]),
            .d_out (sq_chain[l][k+1])
         );
      end

      cordic_type prep_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            prep_ff <= prep_in[l];
         end
      end
      assign cd_chain[l][0] = prep_ff;

      for (genvar k = 0; k < NSTEP; k++) begin : g_cordic
         atdc_cordic_cell #(.STAGE(k)) u_cell (
            .clock (clock),
            .en    (en),
            .d_in  (cd_chain[l][k]),
            .d_out (cd_chain[l][k+1])
         );
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ang_ff[l] <= ang_in[l];
         end
      end
   end

   // Operand setup; the Z lane swaps root and side, and every lane rotates a negative abscissa by -90 degrees.
   always_comb begin
      logic signed [CW-1:0] rt;
      logic signed [CW-1:0] sd;
      logic signed [CW-1:0] xv;
      logic signed [CW-1:0] yv;
      for (int l = 0; l < 3; l++) begin
         rt = CW'(signed'({1'b0, sq_chain[l][SQRT_STEPS].root}));
         sd = CW'(sq_chain[l][SQRT_STEPS].side);
         if (l == 2) begin
            xv = sd;
            yv = rt;
         end else begin
            xv = rt;
            yv = sd;
         end
         prep_in[l].zero = (xv == '0) && (yv == '0);
         if (xv[CW-1]) begin
            prep_in[l].x   = yv;
            prep_in[l].y   = -xv;
            prep_in[l].acc = ACC90;
         end else begin
            prep_in[l].x   = xv;
            prep_in[l].y   = yv;
            prep_in[l].acc = '0;
         end
      end
   end

   // Rounding to output units and range clamp.
   always_comb begin
      logic signed [AW-1:0] v;
      logic signed [AW-1:0] lo;
      logic signed [AW-1:0] hi;
      for (int l = 0; l < 3; l++) begin
         v  = (cd_chain[l][NSTEP].acc + HALF) >>> SH;
         lo = (l == 2) ? AW'(0) : -LIM90;
         hi = (l == 2) ? LIM180 : LIM90;
         if (cd_chain[l][NSTEP].zero) begin
            v = '0;
         end else if (v < lo) begin
            v = lo;
         end else if (v > hi) begin
            v = hi;
         end
         ang_in[l] = ANG_W'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tilt_x_ff <= OUT_W'(ang_ff[0]);
         tilt_y_ff <= OUT_W'(ang_ff[1]);
         tilt_z_ff <= OUT_W'(ang_ff[2]);
         turn_x_ff <= turn_dec(ERR_W'(ref_x_ff) - ERR_W'(ang_ff[0]), db_xy_ff);
         turn_y_ff <= turn_dec(ERR_W'(ref_y_ff) - ERR_W'(ang_ff[1]), db_xy_ff);
         turn_z_ff <= turn_dec(ERR_W'(ref_z_ff) - ERR_W'(ang_ff[2]), db_z_ff);
      end
   end

   assign rsp_valid  = vld_ff[LAT-1];
   assign rsp_tilt_x = tilt_x_ff;
   assign rsp_tilt_y = tilt_y_ff;
   assign rsp_tilt_z = tilt_z_ff;
   assign rsp_turn_x = turn_x_ff;
   assign rsp_turn_y = turn_y_ff;
   assign rsp_turn_z = turn_z_ff;

   `ATDC_ASSERT_IMPL(a_stall_only_on_held_result, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ATDC_ASSERT_IMPL(a_empty_output_takes_input, clock, reset, !rsp_valid, !req_stall)
   `ATDC_ASSERT_NEXT(a_held_result_stays, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

@@ hw/rtl/atdc_sqrt_cell.sv @@
// One digit cell of the pipelined square root; resolves one root bit.
// Depends on atdc_pkg.
module atdc_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  atdc_pkg::sqrt_type d_in,
   output atdc_pkg::sqrt_type d_out
);
   import atdc_pkg::*;

   sqrt_type            d_ff;
   sqrt_type            d_in_n;
   logic [REM_W+1:0]    cand;
   logic [REM_W+1:0]    trial;

   always_comb begin
      cand  = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
      trial = {2'b00, d_in.root, 2'b01};
      d_in_n.rad  = {d_in.rad[RAD_W-3:0], 2'b00};
      d_in_n.side = d_in.side;
      if (cand >= trial) begin
         d_in_n.rem  = REM_W'(cand - trial);
         d_in_n.root = {d_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         d_in_n.rem  = cand[REM_W-1:0];
         d_in_n.root = {d_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_n;
      end
   end

   assign d_out = d_ff;

endmodule

@@ hw/rtl/atdc_cordic_cell.sv @@
// One vectoring CORDIC rotation cell with a fixed shift and table entry.
// Depends on atdc_pkg.
module atdc_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  atdc_pkg::cordic_type d_in,
   output atdc_pkg::cordic_type d_out
);
   import atdc_pkg::*;

   cordic_type           d_ff;
   cordic_type           d_in_n;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [AW-1:0] tab;

   always_comb begin
      xs  = d_in.x >>> STAGE;
      ys  = d_in.y >>> STAGE;
      tab = signed'({{(AW-TAB_W){1'b0}}, atan_entry(STAGE)});
      d_in_n.zero = d_in.zero;
      if (!d_in.y[CW-1]) begin
         d_in_n.x   = d_in.x + ys;
         d_in_n.y   = d_in.y - xs;
         d_in_n.acc = d_in.acc + tab;
      end else begin
         d_in_n.x   = d_in.x - ys;
         d_in_n.y   = d_in.y + xs;
         d_in_n.acc = d_in.acc - tab;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_n;
      end
   end

   assign d_out = d_ff;

endmodule

@@ test/atdc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the tilt corrector: watches request, response and register ports,
// predicts each tilt result and compares it. Depends on atdc_pkg.
module atdc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [atdc_pkg::AXIS_W-1:0]  req_accel_x,
   input  logic signed [atdc_pkg::AXIS_W-1:0]  req_accel_y,
   input  logic signed [atdc_pkg::AXIS_W-1:0]  req_accel_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [atdc_pkg::OUT_W-1:0]   rsp_tilt_x,
   input  logic signed [atdc_pkg::OUT_W-1:0]   rsp_tilt_y,
   input  logic [atdc_pkg::OUT_W-1:0]          rsp_tilt_z,
   input  logic [1:0]                          rsp_turn_x,
   input  logic [1:0]                          rsp_turn_y,
   input  logic [1:0]                          rsp_turn_z,
   input  logic                                csr_wr_en,
   input  logic [atdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [atdc_pkg::CFG_W-1:0]          csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count
);
   import atdc_pkg::*;

   localparam int STEPS = 16;
   localparam int FRAC = 8;

   typedef struct packed {
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      logic [15:0]        tz;
      logic [1:0]         dx;
      logic [1:0]         dy;
      logic [1:0]         dz;
   } tilt_type;

   tilt_type expected_tilts[$];
   logic signed [16:0] base_x, base_y, base_z;
   logic [15:0] band_xy, band_z;

   const longint arctan_deg[24] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115};

   function automatic longint root_scaled(longint p, longint q);
      longint n, r, b;
      n = (p * p + q * q) << 16;
      r = 0;
      b = longint'(1) << 60;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint acc, t, xs, ys;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         acc = longint'(90) << 24;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            acc += arctan_deg[i];
         end else begin
            x = x - ys;
            y = y + xs;
            acc -= arctan_deg[i];
         end
      end
      return acc;
   endfunction

   function automatic longint round_clamp(longint acc, longint lo, longint hi);
      longint v;
      v = (acc + (longint'(1) << (24 - FRAC - 1))) >>> (24 - FRAC);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic turn_type turn_for(longint target, longint angle, longint band);
      longint err, mag;
      err = target - angle;
      mag = err < 0 ? -err : err;
      if (mag <= band) return TURN_NONE;
      return err > 0 ? TURN_CW : TURN_CCW;
   endfunction

   function automatic tilt_type predict_tilt(longint ax, longint ay, longint az);
      tilt_type r;
      longint tx, ty, tz, l90, l180;
      l90 = longint'(90) << FRAC;
      l180 = longint'(180) << FRAC;
      tx = round_clamp(vector_angle(ax * 256, root_scaled(ay, az)), -l90, l90);
      ty = round_clamp(vector_angle(ay * 256, root_scaled(ax, az)), -l90, l90);
      tz = round_clamp(vector_angle(root_scaled(ax, ay), az * 256), 0, l180);
      r.tx = tx[15:0];
      r.ty = ty[15:0];
      r.tz = tz[15:0];
      r.dx = turn_for(base_x, tx, band_xy);
      r.dy = turn_for(base_y, ty, band_xy);
      r.dz = turn_for(base_z, tz, band_z);
      return r;
   endfunction

   always @(posedge clock) begin
      tilt_type e, a;
      if (reset) begin
         base_x <= '0;
         base_y <= '0;
         base_z <= '0;
         band_xy <= DB_XY_RESET;
         band_z <= DB_Z_RESET;
         expected_tilts.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REF_X: base_x <= csr_wdata;
               CSR_REF_Y: base_y <= csr_wdata;
               CSR_REF_Z: base_z <= csr_wdata;
               CSR_DB_XY: band_xy <= csr_wdata[15:0];
               CSR_DB_Z: band_z <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_tilts.push_back(predict_tilt(req_accel_x, req_accel_y, req_accel_z));
         if (rsp_valid && !rsp_stall) begin
            a = '{rsp_tilt_x, rsp_tilt_y, rsp_tilt_z, rsp_turn_x, rsp_turn_y, rsp_turn_z};
            if (expected_tilts.size() == 0) begin
               if (fail_count < 10) $display("unexpected transaction: %p", a);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_tilts.pop_front();
               if (e !== a) begin
                  if (fail_count < 10) $display("mismatch: expected %p, actual %p", e, a);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_tilts.size();
      end
   end

endmodule

@@ test/tb_accel_tilt_deadband_corrector.sv @@
`timescale 1ns / 1ps
// Top of the tilt corrector testbench: drives samples and register writes,
// stalls the response side and gives the verdict. Depends on atdc_pkg and atdc_checker.
module tb_accel_tilt_deadband_corrector;
   import atdc_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_wr_en = 0;
   logic req_stall, rsp_valid;
   logic signed [15:0] req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic signed [15:0] rsp_tilt_x, rsp_tilt_y;
   logic [15:0] rsp_tilt_z;
   logic [1:0] rsp_turn_x, rsp_turn_y, rsp_turn_z;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;
   int fail_count, pending_count, cycle_count = 0;
   bit quiet = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   accel_tilt_deadband_corrector u_top (.*);

   atdc_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      csr_wr_en <= 0;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_accel_x <= x;
      req_accel_y <= y;
      req_accel_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CFG_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic random_samples(int count);
      logic [15:0] v[3];
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
               0: v[k] = $urandom;
               1: v[k] = $urandom_range(0, 600) - 300;
               2: v[k] = $urandom_range(0, 1) ? 16'h7fff - $urandom_range(0, 50)
                                              : 16'h8000 + $urandom_range(0, 50);
               default: v[k] = $urandom_range(0, 8000) - 4000;
            endcase
         end
         send_sample(v[0], v[1], v[2]);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_sample(0, 0, 0);
      send_sample(16'h7fff, 0, 0);
      send_sample(16'h8000, 0, 0);
      send_sample(0, 16'h7fff, 0);
      send_sample(0, 16'h8000, 0);
      send_sample(0, 0, 16'h7fff);
      send_sample(0, 0, 16'h8000);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'h7fff, 16'h8000, 16'hffff);
      send_sample(1, 0, 16'hffff);
      send_sample(0, 1, 16'hffff);
      send_sample(1, 1, 1);
      send_sample(16'hffff, 16'hffff, 16'hffff);
      send_sample(100, 0, 16'hffff);
      send_sample(0, 0, 1);
      drain();
      write_reg(CSR_REF_X, 17'sd46080);
      write_reg(CSR_REF_Y, -17'sd46080);
      write_reg(CSR_REF_Z, 17'sd46080);
      write_reg(CSR_DB_XY, 16'd0);
      write_reg(CSR_DB_Z, 16'd0);
      random_samples(400);
      drain();
      write_reg(CSR_REF_X, -17'sd46080);
      write_reg(CSR_REF_Y, 17'sd46080);
      write_reg(CSR_REF_Z, -17'sd46080);
      write_reg(CSR_DB_XY, 16'd46080);
      write_reg(CSR_DB_Z, 16'd46080);
      random_samples(300);
      drain();
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_REF_X, $urandom_range(0, 92160) - 46080);
         write_reg(CSR_REF_Y, $urandom_range(0, 92160) - 46080);
         write_reg(CSR_REF_Z, $urandom_range(0, 92160) - 46080);
         write_reg(CSR_DB_XY, $urandom_range(0, 3000));
         write_reg(CSR_DB_Z, $urandom_range(0, 3000));
         random_samples(200);
         drain();
      end
      write_reg(CSR_REF_X, 17'h1ffff);
      write_reg(CSR_REF_Y, 17'h10000);
      write_reg(CSR_REF_Z, 17'h0ffff);
      write_reg(CSR_DB_XY, 16'hffff);
      write_reg(CSR_DB_Z, 16'h8000);
      random_samples(100);
      drain();
      write_reg(CSR_DB_XY, 16'd640);
      write_reg(CSR_DB_Z, 16'd256);
      quiet = 1;
      random_samples(200);
      drain();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
